### hdl/binary_to_ascii_formatter_defines.svh
// Assertion macros for the formatter RTL.
`ifndef BINARY_TO_ASCII_FORMATTER_DEFINES_SVH
`define BINARY_TO_ASCII_FORMATTER_DEFINES_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset.
`define BTA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Expression that must never be true out of reset.
`define BTA_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition");
`else
`define BTA_ASSERT(lbl, clk, rst, prop)
`define BTA_NEVER(lbl, clk, rst, expr)
`endif
`endif

### hdl/bta_pkg.sv
`timescale 1ns / 1ps
package bta_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned NumDigits  = 10;
   localparam int unsigned BcdWidth   = 4 * NumDigits;
   localparam int unsigned StepsPerStage = 8;
   localparam int unsigned MaxPrec    = 9;

   localparam logic [1:0] OP_HEX  = 2'd0;
   localparam logic [1:0] OP_UDEC = 2'd1;
   localparam logic [1:0] OP_SFIX = 2'd2;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_POINT = 8'h2E;

   // Per-item side information that travels alongside the conversion
   typedef struct packed {
      logic                 hexm;
      logic                 neg;
      logic [3:0]           prec;
      logic [WordWidth-1:0] word;
   } bta_side_type;

   // Double-dabble working state for one item
   typedef struct packed {
      bta_side_type         side;
      logic [BcdWidth-1:0]  bcd;
      logic [WordWidth-1:0] bin;
   } bta_dab_type;

   // Upper-case hex character of one nibble
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      case (nib)
         4'hA:    c = 8'h41;
         4'hB:    c = 8'h42;
         4'hC:    c = 8'h43;
         4'hD:    c = 8'h44;
         4'hE:    c = 8'h45;
         4'hF:    c = 8'h46;
         default: c = CH_ZERO + {4'd0, nib};
      endcase
      return c;
   endfunction

endpackage

### hdl/bta_front.sv
`timescale 1ns / 1ps
module bta_front
   import bta_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic [1:0]           op,
   input  logic [WordWidth-1:0] value,
   input  logic [3:0]           precision,
   output logic                 out_valid,
   output bta_dab_type          out_dab
);

   logic        valid_ff;
   bta_dab_type dab_ff, dab_in;
   logic        neg;

   // Take magnitude and clamp precision; unused op yields nothing
   always_comb begin
      neg                = (op == OP_SFIX) && value[WordWidth-1];
      dab_in.side.hexm   = (op == OP_HEX);
      dab_in.side.neg    = neg;
      dab_in.side.prec   = (op != OP_SFIX) ? 4'd0 :
                           (precision > 4'(MaxPrec)) ? 4'(MaxPrec) : precision;
      dab_in.side.word   = value;
      dab_in.bcd         = '0;
      dab_in.bin         = neg ? (~value + 1'b1) : value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid && (op == OP_HEX || op == OP_UDEC || op == OP_SFIX);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dab_ff <= dab_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_dab   = dab_ff;

endmodule

### hdl/bta_dabble.sv
`timescale 1ns / 1ps
module bta_dabble
   import bta_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  bta_dab_type in_dab,
   output logic        out_valid,
   output bta_dab_type out_dab
);

   logic        valid_ff;
   bta_dab_type dab_ff, dab_in;

   // Run eight shift-add-3 steps on the BCD accumulator
   always_comb begin
      logic [BcdWidth-1:0]  bcd;
      logic [WordWidth-1:0] bin;
      bcd = in_dab.bcd;
      bin = in_dab.bin;
      for (int s = 0; s < StepsPerStage; s++) begin
         for (int d = 0; d < NumDigits; d++) begin
            if (bcd[4*d +: 4] >= 4'd5) begin
               bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
            end
         end
         bcd = {bcd[BcdWidth-2:0], bin[WordWidth-1]};
         bin = {bin[WordWidth-2:0], 1'b0};
      end
      dab_in.side = in_dab.side;
      dab_in.bcd  = bcd;
      dab_in.bin  = bin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dab_ff <= dab_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_dab   = dab_ff;

endmodule

### hdl/bta_serial.sv
`timescale 1ns / 1ps
`include "binary_to_ascii_formatter_defines.svh"
module bta_serial
   import bta_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  bta_dab_type in_dab,
   output logic        adv,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [7:0]  out_ch,
   output logic        out_last
);

   logic       busy_ff, busy_in;
   logic       hexm_ff, hexm_in;
   logic [1:0] pre_ff, pre_in;
   logic       dot_ff, dot_in;
   logic [3:0] idx_ff, idx_in;
   logic [3:0] prec_ff, prec_in;
   logic [3:0] dig_ff [NumDigits];
   logic [3:0] dig_in [NumDigits];
   logic [3:0] hi;
   logic [3:0] top;
   logic       handoff;
   logic       load;

   // Find the highest non-zero decimal digit and the first digit to send
   always_comb begin
      hi = 4'd0;
      for (int i = 0; i < NumDigits; i++) begin
         if (in_dab.bcd[4*i +: 4] != 4'd0) begin
            hi = 4'(i);
         end
      end
      if (in_dab.side.hexm) begin
         top = 4'd7;
      end else begin
         top = (hi > in_dab.side.prec) ? hi : in_dab.side.prec;
      end
   end

   assign out_last = (pre_ff == 2'd0) && !dot_ff && (idx_ff == 4'd0);
   assign handoff  = busy_ff && out_ready;
   assign adv      = !busy_ff || (handoff && out_last);
   assign load     = adv && in_valid;

   // Advance through prefix, digits and point; load the next item at the end or when idle
   always_comb begin
      busy_in = busy_ff;
      hexm_in = hexm_ff;
      pre_in  = pre_ff;
      dot_in  = dot_ff;
      idx_in  = idx_ff;
      prec_in = prec_ff;
      dig_in  = dig_ff;
      if (handoff) begin
         if (pre_ff != 2'd0) begin
            pre_in = pre_ff - 2'd1;
         end else if (dot_ff) begin
            dot_in = 1'b0;
         end else if (idx_ff == 4'd0) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff - 4'd1;
            dot_in = (prec_ff != 4'd0) && (idx_ff == prec_ff);
         end
      end
      if (load) begin
         busy_in = 1'b1;
         hexm_in = in_dab.side.hexm;
         pre_in  = in_dab.side.hexm ? 2'd2 : (in_dab.side.neg ? 2'd1 : 2'd0);
         dot_in  = 1'b0;
         idx_in  = top;
         prec_in = in_dab.side.prec;
         for (int i = 0; i < NumDigits; i++) begin
            if (in_dab.side.hexm) begin
               dig_in[i] = (i < 8) ? in_dab.side.word[4*(i & 7) +: 4] : 4'd0;
            end else begin
               dig_in[i] = in_dab.bcd[4*i +: 4];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pre_ff  <= 2'd0;
         dot_ff  <= 1'b0;
         idx_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         pre_ff  <= pre_in;
         dot_ff  <= dot_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      hexm_ff <= hexm_in;
      prec_ff <= prec_in;
      dig_ff  <= dig_in;
   end

   // Pick the character at the current position
   always_comb begin
      if (pre_ff == 2'd2) begin
         out_ch = CH_ZERO;
      end else if (pre_ff == 2'd1) begin
         out_ch = hexm_ff ? CH_X : CH_MINUS;
      end else if (dot_ff) begin
         out_ch = CH_POINT;
      end else begin
         out_ch = hex_char(dig_ff[idx_ff]);
      end
   end

   assign out_valid = busy_ff;

   `BTA_ASSERT(a_end_clears, clock, reset, (handoff && out_last && !in_valid) |=> !busy_ff)
   `BTA_ASSERT(a_idx_range, clock, reset, busy_ff |-> (idx_ff <= 4'd9))
   `BTA_NEVER(a_dot_after_prefix, clock, reset, busy_ff && dot_ff && (pre_ff != 2'd0))
   `BTA_ASSERT(a_hex_idx, clock, reset, (busy_ff && hexm_ff) |-> (idx_ff <= 4'd7))

endmodule

### hdl/binary_to_ascii_formatter.sv
`timescale 1ns / 1ps
// Formats one 32-bit word per input item as ASCII text and sends the text one
// character per output item, with tlast on the final character. Op 0 gives
// "0x" and eight upper-case hex digits, op 1 the unsigned decimal value, op 2
// the signed value scaled by ten to the power of the precision (0..9, larger
// values clamp to 9), with a minus sign, integer part and fraction digits;
// op 3 is accepted and produces no output. The decimal conversion runs in a
// six-stage pipeline (magnitude stage, four double-dabble stages of eight bits
// each, serialiser). The serialiser emits one character per cycle while
// rsp_tready is high and takes the next item as it hands off the last
// character. An item has 10 characters for hex and 1 to 12 for decimal.
module binary_to_ascii_formatter
   import bta_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // value[31:0], precision[35:32], zero pad
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // ch[7:0]
   output logic        rsp_tlast
);

   localparam int unsigned NumDab = WordWidth / StepsPerStage;

   logic        adv;
   logic        v [NumDab+1];
   bta_dab_type d [NumDab+1];

   bta_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .op        (req_tuser),
      .value     (req_tdata[31:0]),
      .precision (req_tdata[35:32]),
      .out_valid (v[0]),
      .out_dab   (d[0])
   );

   for (genvar g = 0; g < NumDab; g++) begin : g_dab
      bta_dabble u_dab (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (v[g]),
         .in_dab    (d[g]),
         .out_valid (v[g+1]),
         .out_dab   (d[g+1])
      );
   end

   bta_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v[NumDab]),
      .in_dab    (d[NumDab]),
      .adv       (adv),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_ch    (rsp_tdata),
      .out_last  (rsp_tlast)
   );

   assign req_tready = adv;

endmodule

### test/bta_checker.sv
`timescale 1ns / 1ps
module bta_checker
   import bta_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending,
   output int          chars_seen
);

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } char_type;

   char_type expected_chars[$];

   // Append the unsigned decimal digits of v, no leading zeros
   function automatic void push_decimal(ref char_type q[$], input logic [31:0] v);
      logic [7:0] digs[10];
      int k;
      k = 0;
      do begin
         digs[k] = 8'h30 + 8'(v % 10);
         v = v / 10;
         k++;
      end while (v != 0);
      while (k > 0) begin
         k--;
         q.push_back('{digs[k], 1'b0});
      end
   endfunction

   // Build the expected text of one item
   function automatic void format_word(logic [1:0] op, logic [31:0] value,
                                       logic [3:0] prec);
      char_type q[$];
      logic [31:0] mag, div, frac, d;
      logic [3:0] nib;
      if (op == OP_HEX) begin
         q.push_back('{CH_ZERO, 1'b0});
         q.push_back('{CH_X, 1'b0});
         for (int sh = 28; sh >= 0; sh -= 4) begin
            nib = value[sh +: 4];
            q.push_back('{(nib < 10) ? 8'h30 + nib : 8'h37 + nib, 1'b0});
         end
      end else if (op == OP_UDEC) begin
         push_decimal(q, value);
      end else if (op == OP_SFIX) begin
         if (prec > MaxPrec) prec = 4'(MaxPrec);
         mag = value;
         if (value[31]) begin
            q.push_back('{CH_MINUS, 1'b0});
            mag = -value;
         end
         div = 1;
         for (int i = 0; i < prec; i++) div = div * 10;
         push_decimal(q, mag / div);
         if (prec > 0) begin
            frac = mag % div;
            q.push_back('{CH_POINT, 1'b0});
            for (d = div / 10; d > 0; d = d / 10)
               q.push_back('{8'h30 + 8'((frac / d) % 10), 1'b0});
         end
      end
      if (q.size() > 0) q[q.size() - 1].last = 1'b1;
      foreach (q[i]) expected_chars.push_back(q[i]);
   endfunction

   assign pending = expected_chars.size();

   // Predict on each accepted item, compare each accepted character
   always @(posedge clock) begin
      char_type want;
      if (reset) begin
         fail_count <= 0;
         chars_seen <= 0;
      end else begin
         if (req_tvalid && req_tready)
            format_word(req_tuser, req_tdata[31:0], req_tdata[35:32]);
         if (rsp_tvalid && rsp_tready) begin
            chars_seen <= chars_seen + 1;
            if (expected_chars.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected character %h last %b", rsp_tdata, rsp_tlast);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_chars.pop_front();
               if (want.ch !== rsp_tdata || want.last !== rsp_tlast) begin
                  if (fail_count < 10)
                     $display("mismatch: expected ch %h last %b, got ch %h last %b",
                              want.ch, want.last, rsp_tdata, rsp_tlast);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

### test/tb_binary_to_ascii_formatter.sv
`timescale 1ns / 1ps
module tb_binary_to_ascii_formatter;
   import bta_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   int          fail_count, pending, chars_seen;
   int          send_idle = 0, recv_idle = 0;
   int          items_sent = 0;

   always #4 clock = ~clock;

   binary_to_ascii_formatter u_top (.*);

   bta_checker u_check (.*);

   // Receiver stalls at the set rate
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle);

   // Offer one item, idling beforehand at the sender rate
   task automatic send_item(logic [1:0] op, logic [31:0] value, logic [3:0] prec);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, prec, value};
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // Random item, biased toward edge magnitudes
   task automatic send_random();
      logic [31:0] v;
      case ($urandom_range(5))
         0: v = $urandom_range(20);
         1: v = 32'h8000_0000 + $urandom_range(3);
         2: v = 32'hFFFF_FFFF - $urandom_range(20);
         3: v = $urandom_range(999_999);
         default: v = $urandom;
      endcase
      send_item(($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2)), v,
                4'($urandom_range(15)));
   endtask

   initial begin
      #2_000_000;
      $display("binary_to_ascii_formatter test failed");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Directed: extremes of every op, the most negative value, clamped precision
      send_item(OP_HEX, 32'h0, 4'd0);
      send_item(OP_HEX, 32'hFFFF_FFFF, 4'd15);
      send_item(OP_HEX, 32'h1234_ABCD, 4'd0);
      send_item(OP_UDEC, 32'h0, 4'd0);
      send_item(OP_UDEC, 32'hFFFF_FFFF, 4'd0);
      send_item(OP_UDEC, 32'd1_000_000_000, 4'd5);
      send_item(OP_SFIX, 32'h0, 4'd0);
      send_item(OP_SFIX, 32'h0, 4'd9);
      send_item(OP_SFIX, 32'h8000_0000, 4'd0);
      send_item(OP_SFIX, 32'h8000_0000, 4'd9);
      send_item(OP_SFIX, 32'h7FFF_FFFF, 4'd9);
      send_item(OP_SFIX, 32'hFFFF_FFFF, 4'd3);
      send_item(OP_SFIX, 32'd5, 4'd15);
      send_item(OP_SFIX, 32'd12345, 4'd10);
      send_item(OP_SFIX, 32'd1005, 4'd2);
      send_item(2'd3, 32'hFFFF_FFFF, 4'd15);
      send_item(2'd3, 32'h0, 4'd0);
      // Random in three idling phases
      send_idle = 12; recv_idle = 75;
      repeat (150) send_random();
      send_idle = 75; recv_idle = 12;
      repeat (150) send_random();
      send_idle = 0; recv_idle = 0;
      repeat (145) send_random();
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d items over all ops and %0d characters", items_sent,
               chars_seen);
      if (fail_count == 0 && pending == 0)
         $display("binary_to_ascii_formatter test passed");
      else
         $display("binary_to_ascii_formatter test failed");
      $finish;
   end

endmodule
